// ===== sv/rmq_pkg.sv =====
// Shared types and constants for the rotation matrix to quaternion converter.
// No dependencies.
`default_nettype none
package rmq_pkg;
    localparam int DataW    = 16;
    localparam int FracBits = 14;
    localparam int ExtW     = DataW + 3;
    localparam int ArgW     = DataW + 1;
    localparam int RootW    = ArgW;
    localparam int MagW     = DataW + 1;
    localparam int QuoW     = DataW;
    localparam int RemW     = 2 * RootW + 2;
    localparam int SqShift  = FracBits + 2;

    typedef logic signed [DataW-1:0] t_data;

    typedef enum logic [1:0] {
        POS_X = 2'd0,
        POS_Y = 2'd1,
        POS_Z = 2'd2,
        POS_W = 2'd3
    } t_pos;

    typedef struct packed {
        t_pos                  pos;
        logic [2:0]            neg;
        logic [2:0][MagW-1:0]  mag;
    } t_side;

    typedef struct packed {
        logic [2:0][QuoW-1:0]  q;
        logic [2:0]            ovf;
    } t_quo;
endpackage
`default_nettype wire

// ===== sv/rmq_sqrt.sv =====
// Pipelined integer square root, one result bit per register stage.
// Depends on rmq_pkg.
`default_nettype none
module rmq_sqrt (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_en,
    input  wire logic                       i_valid,
    input  wire logic [rmq_pkg::ArgW-1:0]   i_arg,
    input  wire rmq_pkg::t_side             i_side,
    output logic                            o_valid,
    output logic [rmq_pkg::RootW-1:0]       o_root,
    output rmq_pkg::t_side                  o_side
);
    import rmq_pkg::*;

    logic              r_valid [0:RootW];
    logic [RemW-1:0]   r_rem   [0:RootW];
    logic [RootW-1:0]  r_res   [0:RootW];
    t_side             r_side  [0:RootW];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid[0] <= 1'b0;
        end else if (i_en) begin
            r_valid[0] <= i_valid;
        end
        if (i_en) begin
            r_rem[0]  <= RemW'({i_arg, SqShift'(0)});
            r_res[0]  <= '0;
            r_side[0] <= i_side;
        end
    end

    for (genvar j = 0; j < RootW; j++) begin : g_stage
        localparam int B = RootW - 1 - j;
        logic [RemW-1:0]  n_trial;
        logic             n_take;
        assign n_trial = (RemW'(r_res[j]) << (B + 1)) + (RemW'(1) << (2 * B));
        assign n_take  = (r_rem[j] >= n_trial);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[j+1] <= 1'b0;
            end else if (i_en) begin
                r_valid[j+1] <= r_valid[j];
            end
            if (i_en) begin
                r_rem[j+1]  <= n_take ? r_rem[j] - n_trial : r_rem[j];
                r_res[j+1]  <= n_take ? (r_res[j] | (RootW'(1) << B)) : r_res[j];
                r_side[j+1] <= r_side[j];
            end
        end
    end

    assign o_valid = r_valid[RootW];
    assign o_root  = r_res[RootW];
    assign o_side  = r_side[RootW];

    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid[RootW] |-> (r_rem[RootW] <= (RemW'(r_res[RootW]) << 1)))
        else $error("square root remainder out of bound");
endmodule
`default_nettype wire

// ===== sv/rmq_div.sv =====
// Pipelined restoring division of three magnitudes by the root, one quotient
// bit per register stage. Depends on rmq_pkg.
`default_nettype none
module rmq_div (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_en,
    input  wire logic                       i_valid,
    input  wire logic [rmq_pkg::RootW-1:0]  i_root,
    input  wire rmq_pkg::t_side             i_side,
    output logic                            o_valid,
    output logic [rmq_pkg::RootW-1:0]       o_root,
    output rmq_pkg::t_side                  o_side,
    output rmq_pkg::t_quo                   o_quo
);
    import rmq_pkg::*;

    logic                  r_valid [0:QuoW];
    logic [RootW-1:0]      r_root  [0:QuoW];
    t_side                 r_side  [0:QuoW];
    logic [2:0][RemW-1:0]  r_rem   [0:QuoW];
    t_quo                  r_quo   [0:QuoW];

    logic [2:0][RemW-1:0]  n_num;
    logic [2:0]            n_ovf;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n_num[k] = RemW'({i_side.mag[k], FracBits'(0)}) + RemW'(i_root >> 1);
            n_ovf[k] = (n_num[k] >= (RemW'(i_root) << QuoW));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid[0] <= 1'b0;
        end else if (i_en) begin
            r_valid[0] <= i_valid;
        end
        if (i_en) begin
            r_root[0]    <= i_root;
            r_side[0]    <= i_side;
            r_rem[0]     <= n_num;
            r_quo[0].q   <= '0;
            r_quo[0].ovf <= n_ovf;
        end
    end

    for (genvar j = 0; j < QuoW; j++) begin : g_stage
        localparam int B = QuoW - 1 - j;
        logic [RemW-1:0]       n_dvs;
        logic [2:0][RemW-1:0]  n_rem;
        t_quo                  n_quo;
        assign n_dvs = RemW'(r_root[j]) << B;

        always_comb begin
            n_quo = r_quo[j];
            for (int k = 0; k < 3; k++) begin
                if (r_rem[j][k] >= n_dvs) begin
                    n_rem[k]      = r_rem[j][k] - n_dvs;
                    n_quo.q[k][B] = 1'b1;
                end else begin
                    n_rem[k] = r_rem[j][k];
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[j+1] <= 1'b0;
            end else if (i_en) begin
                r_valid[j+1] <= r_valid[j];
            end
            if (i_en) begin
                r_root[j+1] <= r_root[j];
                r_side[j+1] <= r_side[j];
                r_rem[j+1]  <= n_rem;
                r_quo[j+1]  <= n_quo;
            end
        end
    end

    assign o_valid = r_valid[QuoW];
    assign o_root  = r_root[QuoW];
    assign o_side  = r_side[QuoW];
    assign o_quo   = r_quo[QuoW];

    a_div_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid[QuoW] && r_root[QuoW] != '0 && !r_quo[QuoW].ovf[0])
            |-> (r_rem[QuoW][0] < RemW'(r_root[QuoW])))
        else $error("division remainder not below divisor");
endmodule
`default_nettype wire

// ===== sv/rotation_matrix_to_quaternion.sv =====
// Top level of the rotation matrix to quaternion converter (Shepperd's method).
// Depends on rmq_pkg, rmq_sqrt and rmq_div.
//
//   channel  direction  handshake           word
//   matrix   in         i_valid / o_stall   nine Q2.14 elements
//   quat     out        o_valid / i_stall   x, y, z, w in Q2.14
//
// One word is accepted per cycle unless the output word waits under stall, which
// holds the whole pipeline. The pipeline has one input stage, 18 root stages, 17
// divider stages and one output stage. Reset clears all valid bits.
`default_nettype none
module rotation_matrix_to_quaternion (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_valid,
    output logic                 o_stall,
    input  wire rmq_pkg::t_data  i_elem_r0c0,
    input  wire rmq_pkg::t_data  i_elem_r0c1,
    input  wire rmq_pkg::t_data  i_elem_r0c2,
    input  wire rmq_pkg::t_data  i_elem_r1c0,
    input  wire rmq_pkg::t_data  i_elem_r1c1,
    input  wire rmq_pkg::t_data  i_elem_r1c2,
    input  wire rmq_pkg::t_data  i_elem_r2c0,
    input  wire rmq_pkg::t_data  i_elem_r2c1,
    input  wire rmq_pkg::t_data  i_elem_r2c2,
    output logic                 o_valid,
    input  wire logic            i_stall,
    output rmq_pkg::t_data       o_quat_x,
    output rmq_pkg::t_data       o_quat_y,
    output rmq_pkg::t_data       o_quat_z,
    output rmq_pkg::t_data       o_quat_w
);
    import rmq_pkg::*;

    localparam logic signed [ExtW-1:0] FixOne = ExtW'(1) << FracBits;
    localparam logic [QuoW:0] SatMag = (QuoW+1)'(1) << (DataW - 1);

    logic en;
    logic r_out_valid;

    assign en      = !(r_out_valid && i_stall);
    assign o_stall = !en;

    logic signed [ExtW-1:0]  e00, e01, e02, e10, e11, e12, e20, e21, e22;
    logic signed [ExtW-1:0]  n_tr, n_arg;
    logic signed [ExtW-1:0]  n_n [0:2];
    logic [ArgW-1:0]         n_argc;
    t_side                   n_side;

    always_comb begin
        e00 = ExtW'(i_elem_r0c0);
        e01 = ExtW'(i_elem_r0c1);
        e02 = ExtW'(i_elem_r0c2);
        e10 = ExtW'(i_elem_r1c0);
        e11 = ExtW'(i_elem_r1c1);
        e12 = ExtW'(i_elem_r1c2);
        e20 = ExtW'(i_elem_r2c0);
        e21 = ExtW'(i_elem_r2c1);
        e22 = ExtW'(i_elem_r2c2);
        n_tr = e00 + e11 + e22;
        if (n_tr > 0) begin
            n_arg      = n_tr + FixOne;
            n_side.pos = POS_W;
            n_n[0]     = e12 - e21;
            n_n[1]     = e20 - e02;
            n_n[2]     = e01 - e10;
        end else if (e00 > e11 && e00 > e22) begin
            n_arg      = FixOne + e00 - e11 - e22;
            n_side.pos = POS_X;
            n_n[0]     = e10 + e01;
            n_n[1]     = e20 + e02;
            n_n[2]     = e12 - e21;
        end else if (e11 > e22) begin
            n_arg      = FixOne + e11 - e00 - e22;
            n_side.pos = POS_Y;
            n_n[0]     = e10 + e01;
            n_n[1]     = e21 + e12;
            n_n[2]     = e20 - e02;
        end else begin
            n_arg      = FixOne + e22 - e00 - e11;
            n_side.pos = POS_Z;
            n_n[0]     = e20 + e02;
            n_n[1]     = e21 + e12;
            n_n[2]     = e01 - e10;
        end
        n_argc = (n_arg > 0) ? n_arg[ArgW-1:0] : '0;
        for (int k = 0; k < 3; k++) begin
            n_side.neg[k] = n_n[k][ExtW-1];
            n_side.mag[k] = n_side.neg[k] ? MagW'(-n_n[k]) : MagW'(n_n[k]);
        end
    end

    logic             r_in_valid;
    logic [ArgW-1:0]  r_in_arg;
    t_side            r_in_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (en) begin
            r_in_valid <= i_valid;
        end
        if (en) begin
            r_in_arg  <= n_argc;
            r_in_side <= n_side;
        end
    end

    logic              sq_valid;
    logic [RootW-1:0]  sq_root;
    t_side             sq_side;

    rmq_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_in_valid),
        .i_arg   (r_in_arg),
        .i_side  (r_in_side),
        .o_valid (sq_valid),
        .o_root  (sq_root),
        .o_side  (sq_side)
    );

    logic              dv_valid;
    logic [RootW-1:0]  dv_root;
    t_side             dv_side;
    t_quo              dv_quo;

    rmq_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (sq_valid),
        .i_root  (sq_root),
        .i_side  (sq_side),
        .o_valid (dv_valid),
        .o_root  (dv_root),
        .o_side  (dv_side),
        .o_quo   (dv_quo)
    );

    t_data       n_val [0:2];
    t_data       n_quarter;
    logic [QuoW:0] n_qs;
    t_data       n_x, n_y, n_z, n_w;
    logic [RootW:0] n_qsum;

    always_comb begin
        n_qsum    = (RootW+1)'(dv_root) + (RootW+1)'(2);
        n_quarter = DataW'(n_qsum >> 2);
        for (int k = 0; k < 3; k++) begin
            if (dv_quo.ovf[k] || {1'b0, dv_quo.q[k]} > SatMag) begin
                n_qs = SatMag;
            end else begin
                n_qs = {1'b0, dv_quo.q[k]};
            end
            if (dv_root == '0) begin
                n_val[k] = '0;
            end else if (dv_side.neg[k]) begin
                n_val[k] = DataW'(-n_qs);
            end else if (n_qs == SatMag) begin
                n_val[k] = DataW'(SatMag - (QuoW+1)'(1));
            end else begin
                n_val[k] = DataW'(n_qs);
            end
        end
        case (dv_side.pos)
            POS_X: begin
                n_x = n_quarter; n_y = n_val[0]; n_z = n_val[1]; n_w = n_val[2];
            end
            POS_Y: begin
                n_x = n_val[0]; n_y = n_quarter; n_z = n_val[1]; n_w = n_val[2];
            end
            POS_Z: begin
                n_x = n_val[0]; n_y = n_val[1]; n_z = n_quarter; n_w = n_val[2];
            end
            default: begin
                n_x = n_val[0]; n_y = n_val[1]; n_z = n_val[2]; n_w = n_quarter;
            end
        endcase
    end

    t_data r_x, r_y, r_z, r_w;
    t_pos  r_out_pos;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= dv_valid;
        end
        if (en) begin
            r_x       <= n_x;
            r_y       <= n_y;
            r_z       <= n_z;
            r_w       <= n_w;
            r_out_pos <= dv_side.pos;
        end
    end

    assign o_valid  = r_out_valid;
    assign o_quat_x = r_x;
    assign o_quat_y = r_y;
    assign o_quat_z = r_z;
    assign o_quat_w = r_w;

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output word valid right after reset");

    a_quarter_sign: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ((r_out_pos == POS_X && !r_x[DataW-1]) ||
                     (r_out_pos == POS_Y && !r_y[DataW-1]) ||
                     (r_out_pos == POS_Z && !r_z[DataW-1]) ||
                     (r_out_pos == POS_W && !r_w[DataW-1])))
        else $error("quarter root component is negative");
endmodule
`default_nettype wire
